FILE: design/aaq_pkg.sv
// Shared types, constants and elaboration-time table builders for the axis-angle converter.
`timescale 1ns / 1ps
`default_nettype none
package aaq_pkg;

  localparam int CORDIC_STEPS  = 24;
  localparam int OUT_FRAC_BITS = 30;
  localparam int TAB_LEN       = 32;
  localparam int CORDIC_ITERS  = (CORDIC_STEPS < TAB_LEN) ? CORDIC_STEPS : TAB_LEN;

  localparam int XY_W = 44;
  localparam int Z_W  = 45;

  localparam int SHIFT_STAGES = 5;
  localparam int SQRT_STEPS   = 32;
  localparam int DIV_STEPS    = 32;

  localparam int NORM_LAT   = 1 + SHIFT_STAGES + 2 + SQRT_STEPS + 1 + DIV_STEPS;
  localparam int CORDIC_LAT = CORDIC_ITERS + 2;
  localparam int ALIGN_LAT  = NORM_LAT - CORDIC_LAT;
  localparam int MUL_LAT    = 2;
  localparam int TOTAL_LAT  = NORM_LAT + MUL_LAT;

  typedef struct packed {
    logic signed [31:0] axis_x;
    logic signed [31:0] axis_y;
    logic signed [31:0] axis_z;
    logic signed [31:0] angle;
  } aaq_in_t;

  typedef struct packed {
    logic signed [31:0] quat_w;
    logic signed [31:0] quat_x;
    logic signed [31:0] quat_y;
    logic signed [31:0] quat_z;
    logic               axis_zero;
  } aaq_out_t;

  typedef struct packed {
    logic signed [32:0] sin31;
    logic signed [31:0] cos_w;
  } aaq_trig_t;

  typedef struct packed {
    logic             zero;
    logic [2:0]       neg;
    logic [2:0][31:0] mag;
  } aaq_unit_t;

  typedef struct packed {
    logic [63:0] q;
    logic [63:0] r;
  } aaq_qr_t;

  function automatic aaq_qr_t const_divmod(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    aaq_qr_t     res;
    rem = '0;
    res = '0;
    for (int k = 63; k >= 0; k--) begin
      rem = {rem[63:0], num[k]};
      if (rem >= {1'b0, den}) begin
        rem = rem - {1'b0, den};
        res.q[k] = 1'b1;
      end
    end
    res.r = rem[63:0];
    return res;
  endfunction

  function automatic logic [63:0] const_isqrt(input logic [63:0] val);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] b;
    v = val;
    res = '0;
    b = 64'd1 << 62;
    for (int k = 0; k < 32; k++) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] atan_recip(input logic [63:0] n);
    logic [63:0] t;
    logic [63:0] n2;
    logic [63:0] sum;
    logic [63:0] k;
    logic [63:0] term;
    t = const_divmod(64'd1 << 62, n).q;
    n2 = n * n;
    sum = '0;
    k = '0;
    for (int j = 0; j < 64; j++) begin
      if (t != 0) begin
        term = const_divmod(t, 2 * k + 1).q;
        if (k[0]) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
        t = const_divmod(t, n2).q;
        k = k + 1;
      end
    end
    return sum;
  endfunction

  function automatic logic [63:0] quarter_q62();
    return atan_recip(64'd2) + atan_recip(64'd3);
  endfunction

  function automatic logic [63:0] atan_q40(input int i);
    logic [63:0] a;
    if (i == 0) begin
      a = quarter_q62();
    end else begin
      a = atan_recip(64'd1 << i);
    end
    return (a + (64'd1 << 21)) >> 22;
  endfunction

  function automatic logic [63:0] calc_pi_q40();
    return (4 * quarter_q62() + (64'd1 << 21)) >> 22;
  endfunction

  function automatic logic [63:0] calc_gain_q40();
    logic [63:0] p;
    logic [63:0] s;
    aaq_qr_t     qr;
    p = 64'd1 << 60;
    for (int i = 0; i < CORDIC_ITERS; i++) begin
      p = p + (p >> (2 * i));
    end
    s = const_isqrt(p);
    qr = const_divmod(64'd1 << 62, s);
    return (qr.q << 8) + const_divmod(qr.r << 8, s).q;
  endfunction

  localparam logic signed [Z_W-1:0]  PI_Z      = Z_W'(calc_pi_q40());
  localparam logic signed [Z_W-1:0]  HALF_PI_Z = Z_W'(calc_pi_q40() >> 1);
  localparam logic signed [XY_W-1:0] GAIN_XY   = XY_W'(calc_gain_q40());

endpackage
`default_nettype wire

FILE: design/axis_angle_to_quaternion_top.sv
// Top level of the axis-angle to unit quaternion converter pipeline.
//
//   Channel   Ports                 Transfer
//   command   start, busy, item     taken when start is high and busy is low
//   result    done, result          valid for the single cycle that done is high
//
// One transaction enters per clock; busy stays low. Each result passes through
// the 32-step square root and the 32-step divide of the axis path, which set
// its delay; the CORDIC path is delayed to match.
// Reset is synchronous and clears every valid bit, so nothing in flight survives it.
// Results cannot be held off; done is a one-cycle strobe.
`timescale 1ns / 1ps
`default_nettype none
module axis_angle_to_quaternion_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  aaq_pkg::aaq_in_t  item,
  output logic              done,
  output aaq_pkg::aaq_out_t result
);

  localparam int D = aaq_pkg::ALIGN_LAT;
  localparam logic signed [31:0] UNIT = 32'(64'd1 << aaq_pkg::OUT_FRAC_BITS);

  logic               cd_valid;
  aaq_pkg::aaq_trig_t cd_trig;
  logic               nm_valid;
  aaq_pkg::aaq_unit_t nm_unit;
  logic               dl_v [D];
  aaq_pkg::aaq_trig_t dl_trig [D];

  assign busy = 1'b0;

  aaq_cordic u_cordic (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start),
    .angle     (item.angle),
    .out_valid (cd_valid),
    .trig      (cd_trig)
  );

  aaq_norm u_norm (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start),
    .axis      ({item.axis_z, item.axis_y, item.axis_x}),
    .out_valid (nm_valid),
    .unit      (nm_unit)
  );

  always_ff @(posedge clk) begin
    dl_trig[0] <= cd_trig;
    for (int i = 1; i < D; i++) begin
      dl_trig[i] <= dl_trig[i-1];
    end
    if (rst) begin
      for (int i = 0; i < D; i++) begin
        dl_v[i] <= 1'b0;
      end
    end else begin
      dl_v[0] <= cd_valid;
      for (int i = 1; i < D; i++) begin
        dl_v[i] <= dl_v[i-1];
      end
    end
  end

  aaq_mul u_mul (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (nm_valid),
    .unit      (nm_unit),
    .trig      (dl_trig[D-1]),
    .out_valid (done),
    .result    (result)
  );

  a_align: assert property (@(posedge clk) disable iff (rst) nm_valid == dl_v[D-1])
    else $error("Axis and angle paths are out of step.");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##(aaq_pkg::TOTAL_LAT) done)
    else $error("Result did not appear at the fixed latency.");

  a_zero_vec: assert property (@(posedge clk) disable iff (rst)
    done && result.axis_zero |-> result.quat_x == 0 && result.quat_y == 0 && result.quat_z == 0)
    else $error("Zero axis gave a nonzero vector part.");

  a_w_range: assert property (@(posedge clk) disable iff (rst)
    done |-> result.quat_w <= UNIT && result.quat_w >= -UNIT)
    else $error("Scalar part is outside the unit range.");

endmodule
`default_nettype wire

FILE: design/aaq_cordic.sv
// Pipelined rotation-mode CORDIC giving cos and sin of half the angle.
`timescale 1ns / 1ps
`default_nettype none
module aaq_cordic (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic signed [31:0]  angle,
  output logic                out_valid,
  output aaq_pkg::aaq_trig_t  trig
);

  localparam int N   = aaq_pkg::CORDIC_ITERS;
  localparam int XW  = aaq_pkg::XY_W;
  localparam int ZW  = aaq_pkg::Z_W;
  localparam int OFB = aaq_pkg::OUT_FRAC_BITS;

  localparam logic signed [XW-1:0] S_HALF = XW'(64'd1 << 8);
  localparam logic signed [XW-1:0] S_LIM  = XW'(64'd1 << 31);
  localparam logic signed [XW-1:0] C_HALF = XW'(64'd1 << (39 - OFB));
  localparam logic signed [XW-1:0] C_LIM  = XW'(64'd1 << OFB);

  logic signed [XW-1:0] cx [N+1];
  logic signed [XW-1:0] cy [N+1];
  logic signed [ZW-1:0] cz [N+1];
  logic                 cneg [N+1];
  logic                 cv [N+1];

  logic signed [ZW-1:0] z_ext;
  logic signed [ZW-1:0] z_red;
  logic                 neg_red;

  always_comb begin
    z_ext = {{(ZW - 43){angle[31]}}, angle, 11'b0};
    z_red = z_ext;
    neg_red = 1'b0;
    if (z_ext > aaq_pkg::HALF_PI_Z) begin
      z_red = z_ext - aaq_pkg::PI_Z;
      neg_red = 1'b1;
    end else if (z_ext < -aaq_pkg::HALF_PI_Z) begin
      z_red = z_ext + aaq_pkg::PI_Z;
      neg_red = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    cx[0] <= aaq_pkg::GAIN_XY;
    cy[0] <= '0;
    cz[0] <= z_red;
    cneg[0] <= neg_red;
    if (rst) begin
      cv[0] <= 1'b0;
    end else begin
      cv[0] <= in_valid;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_step
    localparam logic signed [ZW-1:0] ATAN = ZW'(aaq_pkg::atan_q40(i));
    always_ff @(posedge clk) begin
      if (cz[i] >= 0) begin
        cx[i+1] <= cx[i] - (cy[i] >>> i);
        cy[i+1] <= cy[i] + (cx[i] >>> i);
        cz[i+1] <= cz[i] - ATAN;
      end else begin
        cx[i+1] <= cx[i] + (cy[i] >>> i);
        cy[i+1] <= cy[i] - (cx[i] >>> i);
        cz[i+1] <= cz[i] + ATAN;
      end
      cneg[i+1] <= cneg[i];
      if (rst) begin
        cv[i+1] <= 1'b0;
      end else begin
        cv[i+1] <= cv[i];
      end
    end
  end

  logic signed [XW-1:0] xf;
  logic signed [XW-1:0] yf;
  logic signed [XW-1:0] ys;
  logic signed [XW-1:0] xs;
  aaq_pkg::aaq_trig_t   trig_next;

  always_comb begin
    xf = cneg[N] ? -cx[N] : cx[N];
    yf = cneg[N] ? -cy[N] : cy[N];
    ys = (yf + S_HALF) >>> 9;
    xs = (xf + C_HALF) >>> (40 - OFB);
    if (ys > S_LIM) begin
      ys = S_LIM;
    end else if (ys < -S_LIM) begin
      ys = -S_LIM;
    end
    if (xs > C_LIM) begin
      xs = C_LIM;
    end else if (xs < -C_LIM) begin
      xs = -C_LIM;
    end
    trig_next.sin31 = 33'(ys);
    trig_next.cos_w = 32'(xs);
  end

  always_ff @(posedge clk) begin
    trig <= trig_next;
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= cv[N];
    end
  end

endmodule
`default_nettype wire

FILE: design/aaq_norm.sv
// Axis normalization pipeline: magnitude, pre-shift, sum of squares, square root and divide.
`timescale 1ns / 1ps
`default_nettype none
module aaq_norm (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [2:0][31:0]   axis,
  output logic               out_valid,
  output aaq_pkg::aaq_unit_t unit
);

  localparam int NSH = aaq_pkg::SHIFT_STAGES;
  localparam int NSQ = aaq_pkg::SQRT_STEPS;
  localparam int NDV = aaq_pkg::DIV_STEPS;

  logic [2:0][31:0] abs_u;
  logic [31:0]      abs_m;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      abs_u[j] = axis[j][31] ? 32'(-axis[j]) : axis[j];
    end
    abs_m = abs_u[0];
    if (abs_u[1] > abs_m) begin
      abs_m = abs_u[1];
    end
    if (abs_u[2] > abs_m) begin
      abs_m = abs_u[2];
    end
  end

  logic [2:0][31:0] sh_u [NSH+1];
  logic [31:0]      sh_m [NSH+1];
  logic [2:0]       sh_neg [NSH+1];
  logic             sh_v [NSH+1];

  always_ff @(posedge clk) begin
    sh_u[0] <= abs_u;
    sh_m[0] <= abs_m;
    sh_neg[0] <= {axis[2][31], axis[1][31], axis[0][31]};
    if (rst) begin
      sh_v[0] <= 1'b0;
    end else begin
      sh_v[0] <= in_valid;
    end
  end

  for (genvar k = 0; k < NSH; k++) begin : g_shift
    localparam int SH = 16 >> k;
    always_ff @(posedge clk) begin
      if (sh_m[k] < (32'd1 << (31 - SH))) begin
        sh_m[k+1] <= sh_m[k] << SH;
        for (int j = 0; j < 3; j++) begin
          sh_u[k+1][j] <= sh_u[k][j] << SH;
        end
      end else begin
        sh_m[k+1] <= sh_m[k];
        sh_u[k+1] <= sh_u[k];
      end
      sh_neg[k+1] <= sh_neg[k];
      if (rst) begin
        sh_v[k+1] <= 1'b0;
      end else begin
        sh_v[k+1] <= sh_v[k];
      end
    end
  end

  logic [2:0][63:0] sq;
  logic [2:0][31:0] sq_u;
  logic [2:0]       sq_neg;
  logic             sq_zero;
  logic             sq_v;

  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      sq[j] <= 64'(sh_u[NSH][j]) * 64'(sh_u[NSH][j]);
    end
    sq_u <= sh_u[NSH];
    sq_neg <= sh_neg[NSH];
    sq_zero <= (sh_m[NSH] == '0);
    if (rst) begin
      sq_v <= 1'b0;
    end else begin
      sq_v <= sh_v[NSH];
    end
  end

  logic [63:0]      rt_rem [NSQ+1];
  logic [63:0]      rt_res [NSQ+1];
  logic [2:0][31:0] rt_u [NSQ+1];
  logic [2:0]       rt_neg [NSQ+1];
  logic             rt_zero [NSQ+1];
  logic             rt_v [NSQ+1];

  always_ff @(posedge clk) begin
    rt_rem[0] <= sq[0] + sq[1] + sq[2];
    rt_res[0] <= '0;
    rt_u[0] <= sq_u;
    rt_neg[0] <= sq_neg;
    rt_zero[0] <= sq_zero;
    if (rst) begin
      rt_v[0] <= 1'b0;
    end else begin
      rt_v[0] <= sq_v;
    end
  end

  for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
    always_ff @(posedge clk) begin
      if (rt_rem[k] >= rt_res[k] + BIT) begin
        rt_rem[k+1] <= rt_rem[k] - (rt_res[k] + BIT);
        rt_res[k+1] <= (rt_res[k] >> 1) + BIT;
      end else begin
        rt_rem[k+1] <= rt_rem[k];
        rt_res[k+1] <= rt_res[k] >> 1;
      end
      rt_u[k+1] <= rt_u[k];
      rt_neg[k+1] <= rt_neg[k];
      rt_zero[k+1] <= rt_zero[k];
      if (rst) begin
        rt_v[k+1] <= 1'b0;
      end else begin
        rt_v[k+1] <= rt_v[k];
      end
    end
  end

  logic [2:0][31:0] dv_rem [NDV+1];
  logic [2:0][31:0] dv_q [NDV+1];
  logic [31:0]      dv_len [NDV+1];
  logic [2:0]       dv_neg [NDV+1];
  logic             dv_zero [NDV+1];
  logic             dv_v [NDV+1];
  logic [2:0]       dv_lsb;

  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      dv_rem[0][j] <= rt_u[NSQ][j] >> 1;
      dv_lsb[j] <= rt_u[NSQ][j][0];
    end
    dv_q[0] <= '0;
    dv_len[0] <= rt_res[NSQ][31:0];
    dv_neg[0] <= rt_neg[NSQ];
    dv_zero[0] <= rt_zero[NSQ];
    if (rst) begin
      dv_v[0] <= 1'b0;
    end else begin
      dv_v[0] <= rt_v[NSQ];
    end
  end

  for (genvar k = 0; k < NDV; k++) begin : g_div
    logic [2:0]       bit_in;
    logic [2:0][32:0] trial;
    assign bit_in = (k == 0) ? dv_lsb : 3'b000;
    always_comb begin
      for (int j = 0; j < 3; j++) begin
        trial[j] = {dv_rem[k][j], bit_in[j]};
      end
    end
    always_ff @(posedge clk) begin
      for (int j = 0; j < 3; j++) begin
        if (trial[j] >= {1'b0, dv_len[k]}) begin
          dv_rem[k+1][j] <= 32'(trial[j] - {1'b0, dv_len[k]});
          dv_q[k+1][j] <= {dv_q[k][j][30:0], 1'b1};
        end else begin
          dv_rem[k+1][j] <= trial[j][31:0];
          dv_q[k+1][j] <= {dv_q[k][j][30:0], 1'b0};
        end
      end
      dv_len[k+1] <= dv_len[k];
      dv_neg[k+1] <= dv_neg[k];
      dv_zero[k+1] <= dv_zero[k];
      if (rst) begin
        dv_v[k+1] <= 1'b0;
      end else begin
        dv_v[k+1] <= dv_v[k];
      end
    end
  end

  assign unit.zero = dv_zero[NDV];
  assign unit.neg  = dv_neg[NDV];
  assign unit.mag  = dv_q[NDV];
  assign out_valid = dv_v[NDV];

endmodule
`default_nettype wire

FILE: design/aaq_mul.sv
// Output stage: scales unit axis by the sine; rounds and saturates the x, y, z parts.
`timescale 1ns / 1ps
`default_nettype none
module aaq_mul (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  aaq_pkg::aaq_unit_t unit,
  input  aaq_pkg::aaq_trig_t trig,
  output logic               out_valid,
  output aaq_pkg::aaq_out_t  result
);

  localparam int OFB = aaq_pkg::OUT_FRAC_BITS;
  localparam logic signed [65:0] R_HALF = 66'(66'd1 << (61 - OFB));
  localparam logic signed [65:0] R_LIM  = 66'(66'd1 << OFB);

  logic signed [65:0] prod [3];
  logic signed [31:0] p_w;
  logic               p_zero;
  logic               p_v;
  logic signed [32:0] nval [3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      nval[j] = unit.neg[j] ? -$signed({1'b0, unit.mag[j]}) : $signed({1'b0, unit.mag[j]});
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      prod[j] <= 66'(nval[j]) * 66'(trig.sin31);
    end
    p_w <= trig.cos_w;
    p_zero <= unit.zero;
    if (rst) begin
      p_v <= 1'b0;
    end else begin
      p_v <= in_valid;
    end
  end

  logic signed [65:0] rnd [3];
  aaq_pkg::aaq_out_t  result_next;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      rnd[j] = (prod[j] + R_HALF) >>> (62 - OFB);
      if (rnd[j] > R_LIM) begin
        rnd[j] = R_LIM;
      end else if (rnd[j] < -R_LIM) begin
        rnd[j] = -R_LIM;
      end
      if (p_zero) begin
        rnd[j] = '0;
      end
    end
    result_next.quat_w    = p_w;
    result_next.quat_x    = 32'(rnd[0]);
    result_next.quat_y    = 32'(rnd[1]);
    result_next.quat_z    = 32'(rnd[2]);
    result_next.axis_zero = p_zero;
  end

  always_ff @(posedge clk) begin
    result <= result_next;
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= p_v;
    end
  end

endmodule
`default_nettype wire
